// ===== hw/rtl/c3x3_pkg.sv =====
// shared constants, types and helper functions of the 3x3 convolution block
`timescale 1ns / 1ps

package c3x3_pkg;

	// largest frame the row stores are sized for
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;

	// fixed field widths
	localparam int PIX_W     = 8;
	localparam int COEF_W    = 8;
	localparam int KROW_W    = 3 * COEF_W;
	localparam int DIM_REG_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = KROW_W;

	// counter widths that follow from the frame limits
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int IROW_W = $clog2(MAX_HEIGHT + 2);

	// arithmetic widths: signed 8 x unsigned 8, three per column, nine in total
	localparam int PROD_W = 16;
	localparam int CSUM_W = 18;
	localparam int SUM_W  = 20;

	// output range and the halving divisor
	localparam int OUT_MAX   = 255;
	localparam int HALF_DIV  = 2;
	localparam int SAT_LIMIT = (OUT_MAX + 1) * HALF_DIV;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4
	} cfg_reg_t;

	// vertical pixel triple, index 0 is the top row
	typedef logic [2:0][PIX_W-1:0] triple_t;

	// coefficients of one kernel column, index 0 is the top row
	typedef logic [2:0][COEF_W-1:0] coef_col_t;

	// per-cell control
	typedef struct packed {
		logic       shift;
		logic       sum;
		logic [2:0] row_en;
		logic       col_en;
	} cell_ctrl_t;

	// border masks and position flags of one result
	typedef struct packed {
		logic rv_top;
		logic rv_bot;
		logic cv_left;
		logic cv_right;
		logic eor;
		logic eof;
	} win_mask_t;

	// width register saturated to 1..MAX_WIDTH
	function automatic logic [WID_W-1:0] sat_width(input logic [DIM_REG_W-1:0] value);
		if (value == '0) return WID_W'(1);
		if (value > DIM_REG_W'(MAX_WIDTH)) return WID_W'(MAX_WIDTH);
		return WID_W'(value);
	endfunction

	// height register saturated to 1..MAX_HEIGHT
	function automatic logic [HGT_W-1:0] sat_height(input logic [DIM_REG_W-1:0] value);
		if (value == '0) return HGT_W'(1);
		if (value > DIM_REG_W'(MAX_HEIGHT)) return HGT_W'(MAX_HEIGHT);
		return HGT_W'(value);
	endfunction

endpackage

// ===== hw/rtl/c3x3_if.sv =====
// stream and configuration interfaces of the 3x3 convolution block
`timescale 1ns / 1ps

interface c3x3_in_if;
	logic                      valid;
	logic                      ready;
	logic [c3x3_pkg::PIX_W-1:0] pixel_in;
	logic                      drain;

	modport source (output valid, output pixel_in, output drain, input ready);
	modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface c3x3_out_if;
	logic                      valid;
	logic                      ready;
	logic [c3x3_pkg::PIX_W-1:0] pixel_out;
	logic                      end_of_row;
	logic                      end_of_frame;

	modport source (output valid, output pixel_out, output end_of_row, output end_of_frame,
		input ready);
	modport sink (input valid, input pixel_out, input end_of_row, input end_of_frame,
		output ready);
endinterface

interface c3x3_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [c3x3_pkg::CFG_IDX_W-1:0] index;
	logic [c3x3_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/conv3x3_zero_pad_half_clamp.sv =====
// top level of the streaming 3x3 convolution with zero padding and half clamp
`timescale 1ns / 1ps

// channel  | role   | payload                                  | transaction when
// ---------+--------+------------------------------------------+------------------
// pixels   | sink   | pixel_in[7:0], drain                     | valid && ready
// results  | source | pixel_out[7:0], end_of_row, end_of_frame | valid && ready
// cfg      | sink   | index[2:0], data[23:0]                   | valid && ready
//
// one pixel per clock while the results are taken; a result leaves through the
// row store read, window cells, column sums and clamp register after the
// transaction that completes its window
// arst_n clears pipeline valids and counters, presets the configuration; the row
// stores and window need no clearing as their contents stay masked until refilled
// each stage moves when the next one is empty or moving, so a stalled result
// only holds back the items behind it; cfg is always ready

module conv3x3_zero_pad_half_clamp (
	input  logic                clk,
	input  logic                arst_n,
	c3x3_in_if.sink             pixels,
	c3x3_out_if.source          results,
	c3x3_cfg_if.sink            cfg
);

	// configuration
	logic [c3x3_pkg::KROW_W-1:0] kernel_q [3];
	logic [c3x3_pkg::WID_W-1:0]  width_q;
	logic [c3x3_pkg::HGT_W-1:0]  height_q;
	logic                        cfg_write;
	logic                        cfg_dim_write;

	// raster counters
	logic [c3x3_pkg::COL_W-1:0]  in_col_q;
	logic [c3x3_pkg::IROW_W-1:0] in_row_q;
	logic [c3x3_pkg::COL_W-1:0]  out_col_q;
	logic [c3x3_pkg::ROW_W-1:0]  out_row_q;

	// accept-side decode
	logic                        accept;
	logic [c3x3_pkg::COL_W-1:0]  col;
	logic [c3x3_pkg::PIX_W-1:0]  px;
	logic                        emit;
	c3x3_pkg::win_mask_t         mask;
	logic [c3x3_pkg::COL_W-1:0]  in_col_nxt;
	logic [c3x3_pkg::IROW_W-1:0] in_row_nxt;
	logic [c3x3_pkg::COL_W-1:0]  out_col_nxt;
	logic [c3x3_pkg::ROW_W-1:0]  out_row_nxt;
	logic                        frame_done;

	// pipeline
	logic                        en_out, en3, en2, en1;
	logic                        v1_q, v2_q, v3_q, ov_q;
	logic [c3x3_pkg::PIX_W-1:0]  px_s1;
	logic [c3x3_pkg::COL_W-1:0]  col_s1;
	logic                        emit_s1;
	c3x3_pkg::win_mask_t         mask_s1;
	c3x3_pkg::win_mask_t         mask_s2;
	logic                        eor_s3, eof_s3;
	logic [c3x3_pkg::PIX_W-1:0]  pixel_out_q;
	logic                        eor_q, eof_q;

	// row stores and window
	logic [2*c3x3_pkg::PIX_W-1:0] rd_data;
	c3x3_pkg::triple_t            new_triple;
	c3x3_pkg::triple_t            triple_1, triple_2;
	c3x3_pkg::coef_col_t          coef_col [3];
	c3x3_pkg::cell_ctrl_t         cell_ctrl [3];
	logic signed [c3x3_pkg::CSUM_W-1:0] col_sum [3];
	logic signed [c3x3_pkg::SUM_W-1:0]  total;
	logic [c3x3_pkg::PIX_W-1:0]   clamped;

	// configuration port, never stalls
	assign cfg.ready     = 1'b1;
	assign cfg_write     = cfg.valid && cfg.ready;
	assign cfg_dim_write = cfg_write &&
		((cfg.index == c3x3_pkg::REG_IMAGE_WIDTH) || (cfg.index == c3x3_pkg::REG_IMAGE_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= '0;
			kernel_q[1] <= c3x3_pkg::KROW_W'(512);
			kernel_q[2] <= '0;
			width_q     <= c3x3_pkg::sat_width(c3x3_pkg::DIM_REG_W'(512));
			height_q    <= c3x3_pkg::sat_height(c3x3_pkg::DIM_REG_W'(512));
		end else if (cfg_write) begin
			case (c3x3_pkg::cfg_reg_t'(cfg.index))
				c3x3_pkg::REG_KERNEL_TOP: begin
					kernel_q[0] <= cfg.data;
				end
				c3x3_pkg::REG_KERNEL_MIDDLE: begin
					kernel_q[1] <= cfg.data;
				end
				c3x3_pkg::REG_KERNEL_BOTTOM: begin
					kernel_q[2] <= cfg.data;
				end
				c3x3_pkg::REG_IMAGE_WIDTH: begin
					width_q <= c3x3_pkg::sat_width(cfg.data[c3x3_pkg::DIM_REG_W-1:0]);
				end
				c3x3_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= c3x3_pkg::sat_height(cfg.data[c3x3_pkg::DIM_REG_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// stall chain from the output register back to the input
	assign en_out       = !ov_q || results.ready;
	assign en3          = !v3_q || en_out;
	assign en2          = !v2_q || en3;
	assign en1          = !v1_q || en2;
	assign pixels.ready = en1;
	assign accept       = pixels.valid && pixels.ready;

	// all counter decisions are taken at the input transaction
	always_comb begin
		logic [c3x3_pkg::WID_W-1:0]  col_inc;
		logic [c3x3_pkg::WID_W-1:0]  ocol_inc;
		logic [c3x3_pkg::HGT_W-1:0]  orow_inc;
		logic                        wrap;
		logic                        drain_phase;

		// a stale column after a size change restarts the row
		col = ({1'b0, in_col_q} >= (c3x3_pkg::COL_W + 1)'(width_q)) ? '0 : in_col_q;

		// past the last row every item is a zero pixel
		drain_phase = (c3x3_pkg::IROW_W'(height_q) <= in_row_q);
		px = (pixels.drain || drain_phase) ? '0 : pixels.pixel_in;

		// first result needs the pixel right of and below its centre
		emit = (in_row_q >= c3x3_pkg::IROW_W'(2)) ||
			((in_row_q == c3x3_pkg::IROW_W'(1)) && (col != '0));

		col_inc = c3x3_pkg::WID_W'(col) + c3x3_pkg::WID_W'(1);
		wrap    = (col_inc >= width_q);
		in_col_nxt = wrap ? '0 : col_inc[c3x3_pkg::COL_W-1:0];
		in_row_nxt = in_row_q;
		if (wrap && (in_row_q < (c3x3_pkg::IROW_W'(height_q) + c3x3_pkg::IROW_W'(1)))) begin
			in_row_nxt = in_row_q + c3x3_pkg::IROW_W'(1);
		end

		// border masks of the result leaving with this item
		ocol_inc = c3x3_pkg::WID_W'(out_col_q) + c3x3_pkg::WID_W'(1);
		orow_inc = c3x3_pkg::HGT_W'(out_row_q) + c3x3_pkg::HGT_W'(1);
		mask.rv_top   = (out_row_q != '0);
		mask.rv_bot   = (orow_inc < height_q);
		mask.cv_left  = (out_col_q != '0);
		mask.cv_right = (ocol_inc < width_q);
		mask.eor      = !mask.cv_right;
		mask.eof      = mask.eor && !mask.rv_bot;

		frame_done  = emit && mask.eof;
		out_col_nxt = out_col_q;
		out_row_nxt = out_row_q;
		if (emit) begin
			if (mask.eor) begin
				out_col_nxt = '0;
				out_row_nxt = out_row_q + c3x3_pkg::ROW_W'(1);
			end else begin
				out_col_nxt = out_col_q + c3x3_pkg::COL_W'(1);
			end
		end
	end

	// a size write or the last result of a frame restarts every counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_dim_write || (accept && frame_done)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_nxt;
			in_row_q  <= in_row_nxt;
			out_col_q <= out_col_nxt;
			out_row_q <= out_row_nxt;
		end
	end

	// stage 1: row store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (en1) begin
			v1_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px;
			col_s1  <= col;
			emit_s1 <= emit;
			mask_s1 <= mask;
		end
	end

	// stores advance by one row at the column: older takes newer, newer takes the pixel
	c3x3_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (v1_q && en2),
		.wr_addr (col_s1),
		.wr_data ({px_s1, rd_data[2*c3x3_pkg::PIX_W-1:c3x3_pkg::PIX_W]}),
		.rd_data (rd_data)
	);

	// stage 2: window cells, only emitting items continue as valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (en2) begin
			v2_q <= v1_q && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v1_q && en2) begin
			mask_s2 <= mask_s1;
		end
	end

	assign new_triple[0] = rd_data[c3x3_pkg::PIX_W-1:0];
	assign new_triple[1] = rd_data[2*c3x3_pkg::PIX_W-1:c3x3_pkg::PIX_W];
	assign new_triple[2] = px_s1;

	// kernel column k feeds cell k, cell 0 is the left column
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				coef_col[k][r] = kernel_q[r][c3x3_pkg::COEF_W*k +: c3x3_pkg::COEF_W];
			end
			cell_ctrl[k].shift  = v1_q && en2;
			cell_ctrl[k].sum    = v2_q && en3;
			cell_ctrl[k].row_en = {mask_s2.rv_bot, 1'b1, mask_s2.rv_top};
		end
		cell_ctrl[0].col_en = mask_s2.cv_left;
		cell_ctrl[1].col_en = 1'b1;
		cell_ctrl[2].col_en = mask_s2.cv_right;
	end

	// new column enters on the right and moves left one cell per item
	c3x3_cell u_cell_right (
		.clk        (clk),
		.ctrl       (cell_ctrl[2]),
		.triple_in  (new_triple),
		.coef       (coef_col[2]),
		.triple_out (triple_2),
		.col_sum    (col_sum[2])
	);

	c3x3_cell u_cell_centre (
		.clk        (clk),
		.ctrl       (cell_ctrl[1]),
		.triple_in  (triple_2),
		.coef       (coef_col[1]),
		.triple_out (triple_1),
		.col_sum    (col_sum[1])
	);

	c3x3_cell u_cell_left (
		.clk        (clk),
		.ctrl       (cell_ctrl[0]),
		.triple_in  (triple_1),
		.coef       (coef_col[0]),
		.triple_out (),
		.col_sum    (col_sum[0])
	);

	// stage 3: column sums registered inside the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (en3) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v2_q && en3) begin
			eor_s3 <= mask_s2.eor;
			eof_s3 <= mask_s2.eof;
		end
	end

	// negative gives zero, otherwise halve and saturate
	always_comb begin
		total = c3x3_pkg::SUM_W'(col_sum[0]) + c3x3_pkg::SUM_W'(col_sum[1]) +
			c3x3_pkg::SUM_W'(col_sum[2]);
		if (total < 0) begin
			clamped = '0;
		end else if (total >= c3x3_pkg::SUM_W'(c3x3_pkg::SAT_LIMIT)) begin
			clamped = c3x3_pkg::PIX_W'(c3x3_pkg::OUT_MAX);
		end else begin
			clamped = total[c3x3_pkg::PIX_W:1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en_out) begin
			ov_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (v3_q && en_out) begin
			pixel_out_q <= clamped;
			eor_q       <= eor_s3;
			eof_q       <= eof_s3;
		end
	end

	assign results.valid        = ov_q;
	assign results.pixel_out    = pixel_out_q;
	assign results.end_of_row   = eor_q;
	assign results.end_of_frame = eof_q;

endmodule

// ===== hw/rtl/c3x3_line_buf.sv =====
// two row stores packed in one memory, read-modify-write per column
`timescale 1ns / 1ps

module c3x3_line_buf (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [c3x3_pkg::COL_W-1:0]   rd_addr,
	input  logic                         wr_en,
	input  logic [c3x3_pkg::COL_W-1:0]   wr_addr,
	input  logic [2*c3x3_pkg::PIX_W-1:0] wr_data,
	output logic [2*c3x3_pkg::PIX_W-1:0] rd_data
);

	// upper byte newer row, lower byte older row
	logic [2*c3x3_pkg::PIX_W-1:0] mem [c3x3_pkg::MAX_WIDTH];
	logic [2*c3x3_pkg::PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// write-first bypass covers a one-pixel-wide frame
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/c3x3_cell.sv =====
// one window column: holds a vertical pixel triple and forms its masked tap sum
`timescale 1ns / 1ps

module c3x3_cell (
	input  logic                               clk,
	input  c3x3_pkg::cell_ctrl_t               ctrl,
	input  c3x3_pkg::triple_t                  triple_in,
	input  c3x3_pkg::coef_col_t                coef,
	output c3x3_pkg::triple_t                  triple_out,
	output logic signed [c3x3_pkg::CSUM_W-1:0] col_sum
);

	c3x3_pkg::triple_t                  pix_q;
	logic signed [c3x3_pkg::PROD_W-1:0] prod [3];
	logic signed [c3x3_pkg::CSUM_W-1:0] csum;
	logic signed [c3x3_pkg::CSUM_W-1:0] col_sum_s3;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			pix_q <= triple_in;
		end
	end

	always_comb begin
		logic signed [c3x3_pkg::PROD_W-1:0] c_ext;
		logic signed [c3x3_pkg::PROD_W-1:0] p_ext;
		csum = '0;
		for (int r = 0; r < 3; r++) begin
			c_ext = c3x3_pkg::PROD_W'($signed(coef[r]));
			p_ext = $signed(c3x3_pkg::PROD_W'(pix_q[r]));
			// taps outside the image count as zero
			prod[r] = (ctrl.row_en[r] && ctrl.col_en) ? c_ext * p_ext : '0;
			csum = csum + c3x3_pkg::CSUM_W'(prod[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sum) begin
			col_sum_s3 <= csum;
		end
	end

	assign triple_out = pix_q;
	assign col_sum    = col_sum_s3;

endmodule

// ===== sim/conv3x3_zero_pad_half_clamp_test.sv =====
// self-checking testbench of the streaming 3x3 convolution with zero padding and half clamp
`timescale 1ns / 1ps

module conv3x3_zero_pad_half_clamp_test;
	import c3x3_pkg::*;

	// time for a result to leave the pipeline after its window completes, with a good margin
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 260;

	// running copy of the block: row stores, window, counters and registers,
	// plus the filtered pixels still owed by the block in order of arrival
	class filter_tracker;
		typedef struct packed {
			logic [PIX_W-1:0] pixel;
			logic             eor;
			logic             eof;
		} filtered_t;

		logic [KROW_W-1:0]    kernel_rows [3];
		logic [DIM_REG_W-1:0] width_reg;
		logic [DIM_REG_W-1:0] height_reg;
		logic [PIX_W-1:0]     older_row [MAX_WIDTH];
		logic [PIX_W-1:0]     newer_row [MAX_WIDTH];
		logic [PIX_W-1:0]     window [3][3];
		int unsigned          in_col, in_row, out_col, out_row;
		filtered_t            awaited [$];
		int                   failures;

		function new();
			kernel_rows[0] = '0;
			kernel_rows[1] = KROW_W'(24'h000200);
			kernel_rows[2] = '0;
			width_reg      = DIM_REG_W'(MAX_WIDTH);
			height_reg     = DIM_REG_W'(MAX_HEIGHT);
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			foreach (window[r, c]) window[r][c] = '0;
			restart();
			failures = 0;
		endfunction

		function void restart();
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		// out-of-range sizes saturate to 1..MAX
		function int unsigned frame_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned frame_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] value);
			case (idx)
			REG_KERNEL_TOP:    kernel_rows[0] = value;
			REG_KERNEL_MIDDLE: kernel_rows[1] = value;
			REG_KERNEL_BOTTOM: kernel_rows[2] = value;
			REG_IMAGE_WIDTH: begin
				width_reg = value[DIM_REG_W-1:0];
				restart();
			end
			REG_IMAGE_HEIGHT: begin
				height_reg = value[DIM_REG_W-1:0];
				restart();
			end
			default: ;
			endcase
		endfunction

		// one accepted pixel transaction; may owe one filtered pixel
		function void take_pixel(logic [PIX_W-1:0] pixel_in, logic drain);
			int unsigned      w, h, col;
			logic [PIX_W-1:0] px;
			bit               fires;
			bit [2:0]         row_ok, col_ok;
			byte              cf;
			int               acc;
			filtered_t        res;
			w   = frame_width();
			h   = frame_height();
			col = in_col;
			px  = drain ? '0 : pixel_in;
			if (col >= w) col = 0;
			// drain phase: whatever arrives counts as a zero pixel
			if (in_row >= h) px = '0;
			for (int r = 0; r < 3; r++) begin
				window[r][0] = window[r][1];
				window[r][1] = window[r][2];
			end
			window[0][2]   = older_row[col];
			window[1][2]   = newer_row[col];
			window[2][2]   = px;
			older_row[col] = newer_row[col];
			newer_row[col] = px;
			fires = (in_row >= 2) || (in_row == 1 && col >= 1);
			col++;
			if (col >= w) begin
				col = 0;
				if (in_row < h + 1) in_row++;
			end
			in_col = col;
			if (!fires) return;

			// border cells count as zero
			row_ok = {out_row + 1 < h, 1'b1, out_row > 0};
			col_ok = {out_col + 1 < w, 1'b1, out_col > 0};
			acc = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					if (row_ok[r] && col_ok[c]) begin
						cf  = kernel_rows[r][c*COEF_W +: COEF_W];
						acc += cf * int'(window[r][c]);
					end
			if (acc < 0) res.pixel = '0;
			else if (acc / HALF_DIV > OUT_MAX) res.pixel = PIX_W'(OUT_MAX);
			else res.pixel = PIX_W'(acc / HALF_DIV);
			res.eor = out_col + 1 >= w;
			res.eof = res.eor && (out_row + 1 >= h);
			awaited.push_back(res);

			if (res.eof) restart();
			else if (res.eor) begin
				out_col = 0;
				out_row++;
			end else out_col++;
		endfunction

		function void match_result(logic [PIX_W-1:0] pixel, logic eor, logic eof);
			filtered_t want;
			if (awaited.size() == 0) begin
				$error("result with none owed: pixel_out %0d end_of_row %0b end_of_frame %0b",
					pixel, eor, eof);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (pixel !== want.pixel) begin
				$error("pixel_out: expected %0d, got %0d", want.pixel, pixel);
				failures++;
			end
			if (eor !== want.eor) begin
				$error("end_of_row: expected %0b, got %0b", want.eor, eor);
				failures++;
			end
			if (eof !== want.eof) begin
				$error("end_of_frame: expected %0b, got %0b", want.eof, eof);
				failures++;
			end
		endfunction
	endclass

	// one pixel-channel transaction to be sent; hold makes the sender wait
	// until every owed result has come before offering it
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             drain;
		logic             hold;
	} feed_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	c3x3_in_if  pixel_ch ();
	c3x3_out_if result_ch ();
	c3x3_cfg_if cfg_ch ();

	conv3x3_zero_pad_half_clamp dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pixel_ch),
		.results (result_ch),
		.cfg     (cfg_ch)
	);

	filter_tracker tracker;
	feed_item_t    feed [$];
	bit            sender_gaps   = 1'b1;
	bit            receiver_gaps = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pixel values lean on the extremes
	function automatic logic [PIX_W-1:0] draw_pixel();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return '1;
		default: return PIX_W'($urandom);
		endcase
	endfunction

	// wild rows use the coefficient extremes and saturate often, tame ones stay small
	function automatic logic [KROW_W-1:0] draw_kernel_row(bit wild);
		logic [KROW_W-1:0] row;
		for (int c = 0; c < 3; c++) begin
			if (wild) begin
				case ($urandom_range(0, 3))
				0:       row[c*COEF_W +: COEF_W] = 8'h80;
				1:       row[c*COEF_W +: COEF_W] = 8'h7f;
				2:       row[c*COEF_W +: COEF_W] = 8'hff;
				default: row[c*COEF_W +: COEF_W] = COEF_W'($urandom);
				endcase
			end else row[c*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(0, 12)) - 6);
		end
		return row;
	endfunction

	// mostly small frames, now and then a zero (saturates to 1) or a wider one
	function automatic logic [DIM_REG_W-1:0] draw_dim(int unsigned cap);
		case ($urandom_range(0, 15))
		0:       return '0;
		1:       return DIM_REG_W'($urandom_range(9, 24));
		default: return DIM_REG_W'($urandom_range(1, cap));
		endcase
	endfunction

	function automatic void queue_item(logic [PIX_W-1:0] pixel, logic drain);
		feed_item_t item;
		item.pixel = pixel;
		item.drain = drain;
		item.hold  = 1'b0;
		feed.push_back(item);
	endfunction

	// a frame of w*h pixels and its w+1 drain items; a noisy frame may carry
	// drains among its pixels, pixels in its drain phase, a cut tail or extras
	function automatic void queue_frame(int unsigned w, int unsigned h, bit noisy);
		int unsigned cut;
		for (int unsigned i = 0; i < w * h; i++)
			queue_item(draw_pixel(), noisy && $urandom_range(0, 19) == 0);
		for (int unsigned i = 0; i <= w; i++)
			queue_item(draw_pixel(), !(noisy && $urandom_range(0, 3) == 0));
		if (noisy) begin
			case ($urandom_range(0, 2))
			0: begin
				cut = $urandom_range(1, w);
				repeat (cut) void'(feed.pop_back());
			end
			1: repeat ($urandom_range(1, 3)) queue_item(draw_pixel(), 1'($urandom));
			default: ;
			endcase
		end
	endfunction

	// idle point: nothing owed, and time for items that owe nothing to clear the pipe
	task automatic settle();
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// offer up to count queued items; valid stays high across back-to-back
	// transactions and is lowered only for a gap, a hold or the end
	task automatic send_feed(input int unsigned count);
		feed_item_t  item;
		int unsigned gap;
		for (int unsigned n = 0; n < count && feed.size() != 0; n++) begin
			item = feed.pop_front();
			gap  = sender_gaps ? $urandom_range(0, 6) : 0;
			if (item.hold || gap > 0) begin
				pixel_ch.valid <= 1'b0;
				if (item.hold) begin
					@(posedge clk);
					while (tracker.awaited.size() != 0) @(posedge clk);
				end
				repeat (gap) @(posedge clk);
			end
			pixel_ch.valid    <= 1'b1;
			pixel_ch.pixel_in <= item.pixel;
			pixel_ch.drain    <= item.drain;
			@(posedge clk);
			while (!pixel_ch.ready) @(posedge clk);
			tracker.take_pixel(item.pixel, item.drain);
		end
		pixel_ch.valid <= 1'b0;
	endtask

	// register writes only ever happen once the block has gone idle; size
	// writes carry random junk above the 10-bit field
	task automatic reconfigure(input bit set_kernel, input logic [KROW_W-1:0] top,
		input logic [KROW_W-1:0] mid, input logic [KROW_W-1:0] bot,
		input bit set_size, input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h);
		cfg_reg_t             idx_q [$];
		logic [CFG_DAT_W-1:0] val_q [$];
		settle();
		if (set_kernel) begin
			idx_q.push_back(REG_KERNEL_TOP);
			val_q.push_back(top);
			idx_q.push_back(REG_KERNEL_MIDDLE);
			val_q.push_back(mid);
			idx_q.push_back(REG_KERNEL_BOTTOM);
			val_q.push_back(bot);
		end
		if (set_size) begin
			idx_q.push_back(REG_IMAGE_WIDTH);
			val_q.push_back({(CFG_DAT_W - DIM_REG_W)'($urandom), w});
			idx_q.push_back(REG_IMAGE_HEIGHT);
			val_q.push_back({(CFG_DAT_W - DIM_REG_W)'($urandom), h});
		end
		foreach (idx_q[i]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx_q[i];
			cfg_ch.data  <= val_q[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			tracker.set_reg(idx_q[i], val_q[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// result side: random stall before each transaction, sampled at the edge
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = receiver_gaps ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			tracker.match_result(result_ch.pixel_out, result_ch.end_of_row,
				result_ch.end_of_frame);
		end
	end

	// stimulus
	initial begin
		int unsigned random_sent;
		bit          first;
		bit          wild;
		tracker = new();
		pixel_ch.valid    <= 1'b0;
		pixel_ch.pixel_in <= '0;
		pixel_ch.drain    <= 1'b0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_KERNEL_TOP;
		cfg_ch.data       <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 512-wide frame with the identity kernel, so the
		// first results of the first row must echo the pixels
		repeat (MAX_WIDTH + 8) queue_item(draw_pixel(), 1'b0);
		send_feed(feed.size());

		// mixed extreme kernel on a 3x3 frame: a drain among the pixels acts as
		// a zero, a pixel in the drain phase counts as drain, and the sender
		// holds mid-frame until all owed results are in
		reconfigure(1'b1, 24'hff7f80, 24'h010201, 24'h80ff7f, 1'b1, 10'd3, 10'd3);
		queue_item(8'hff, 1'b0);
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b0);
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b1);
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b0);
		queue_item(8'h00, 1'b0);
		queue_item(8'hff, 1'b0);
		queue_item(8'h00, 1'b1);
		queue_item(8'hff, 1'b0);
		queue_item(8'h5a, 1'b1);
		queue_item(8'ha5, 1'b1);
		feed[6].hold = 1'b1;
		send_feed(feed.size());

		// largest positive kernel on a single pixel: saturates high
		reconfigure(1'b1, 24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 1'b1, 10'd1, 10'd1);
		queue_item(8'hff, 1'b0);
		queue_item(8'h00, 1'b1);
		queue_item(8'hff, 1'b1);
		send_feed(feed.size());

		// most negative kernel on a bright 2x2 frame: clamps to zero
		reconfigure(1'b1, 24'h808080, 24'h808080, 24'h808080, 1'b1, 10'd2, 10'd2);
		repeat (4) queue_item(8'hff, 1'b0);
		repeat (3) queue_item(8'h00, 1'b1);
		send_feed(feed.size());

		// out-of-range sizes: width above the maximum acts as 512, so a short
		// run owes nothing; zero width with height above the maximum gives a
		// one-pixel column; zero height gives a single row
		reconfigure(1'b1, draw_kernel_row(1'b0), draw_kernel_row(1'b0), draw_kernel_row(1'b0),
			1'b1, 10'h3ff, 10'd1);
		repeat (16) queue_item(draw_pixel(), 1'b0);
		send_feed(feed.size());
		reconfigure(1'b1, draw_kernel_row(1'b1), draw_kernel_row(1'b0), draw_kernel_row(1'b1),
			1'b1, 10'd0, 10'h3ff);
		repeat (12) queue_item(draw_pixel(), 1'b0);
		send_feed(feed.size());
		reconfigure(1'b0, '0, '0, '0, 1'b1, 10'd5, 10'd0);
		queue_frame(tracker.frame_width(), tracker.frame_height(), 1'b0);
		send_feed(feed.size());

		// random phases: a few frames each, mostly clean, some noisy, with
		// occasional kernel changes between transactions of one frame
		random_sent = 0;
		first       = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			sender_gaps   = $urandom_range(0, 3) != 0;
			receiver_gaps = $urandom_range(0, 3) != 0;
			wild          = $urandom_range(0, 3) == 0;
			reconfigure(first || $urandom_range(0, 1) == 0, draw_kernel_row(wild),
				draw_kernel_row(wild), draw_kernel_row(wild),
				first || $urandom_range(0, 2) != 0, draw_dim(8), draw_dim(5));
			first = 1'b0;
			repeat ($urandom_range(1, 3))
				queue_frame(tracker.frame_width(), tracker.frame_height(),
					$urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0) feed[$urandom_range(0, feed.size() - 1)].hold = 1'b1;
			random_sent += feed.size();
			if ($urandom_range(0, 5) == 0) begin
				send_feed($urandom_range(1, feed.size()));
				reconfigure(1'b1, draw_kernel_row(wild), draw_kernel_row(1'b0),
					draw_kernel_row(wild), 1'b0, '0, '0);
			end
			send_feed(feed.size());
		end

		settle();
		if (tracker.failures == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	// hang guard, well beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
